// File: rtl/core/tmwl_pkg.sv
// Shared constants and types for the triangle mesh warp lookup.
package tmwl_pkg;

  localparam int MESH_DEPTH      = 8192;
  localparam int ADDR_W          = $clog2(MESH_DEPTH);
  localparam int COORD_FRAC_BITS = 16;
  localparam int GRID_FRAC       = 25;
  localparam int COORD_W         = 20;
  localparam int WGT_W           = 28;
  localparam int DIFF_W          = COORD_W + 1;
  localparam int PROD_W          = WGT_W + DIFF_W;
  localparam int ACC_W           = 50;
  localparam int RND_SHIFT       = COORD_FRAC_BITS + GRID_FRAC;
  localparam int NUM_READS       = 4;

  // Request kinds carried in the input tuser
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_MAP   = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] REG_INV_STEP_X   = 3'd0;
  localparam logic [2:0] REG_INV_STEP_Y   = 3'd1;
  localparam logic [2:0] REG_LAST_COLUMN  = 3'd2;
  localparam logic [2:0] REG_TEXTURE_SIZE = 3'd3;
  localparam logic [2:0] REG_TEX_OFFSET_X = 3'd4;
  localparam logic [2:0] REG_TEX_OFFSET_Y = 3'd5;
  localparam logic [2:0] REG_ORIGIN_X     = 3'd6;
  localparam logic [2:0] REG_ORIGIN_Y     = 3'd7;

  typedef struct packed {
    logic signed [COORD_W-1:0] v;
    logic signed [COORD_W-1:0] u;
  } node_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    node_t             wdata;
  } mem_wr_t;

endpackage

// File: rtl/core/tmwl_mesh_mem.sv
// Mesh node store: two copies with two registered read ports each.
module tmwl_mesh_mem import tmwl_pkg::*; (
  input  logic                             clk_i,
  input  mem_wr_t                          wr_i,
  input  logic                             re_i,
  input  logic [NUM_READS-1:0][ADDR_W-1:0] raddr_i,
  output node_t [NUM_READS-1:0]            rdata_o
);

  node_t mem_a [MESH_DEPTH];
  node_t mem_b [MESH_DEPTH];
  node_t [NUM_READS-1:0] rdata_q;

  // Write both copies so each holds the full mesh
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_a[wr_i.waddr] <= wr_i.wdata;
      mem_b[wr_i.waddr] <= wr_i.wdata;
    end
  end

  // Read the upper cell row from one copy and the lower from the other
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q[0] <= mem_a[raddr_i[0]];
      rdata_q[1] <= mem_a[raddr_i[1]];
      rdata_q[2] <= mem_b[raddr_i[2]];
      rdata_q[3] <= mem_b[raddr_i[3]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/triangle_mesh_warp_lookup.sv
// Triangle mesh warp lookup: staggered grid search, barycentric blend, viewport scaling.
// Ten register stages carry a map transaction from the accepting edge to the output.
// Throughput: one transaction per cycle unless the output stalls; the node store reads
// four nodes each time stage 5 advances, through two copies with two read ports each.
// Reset: pipeline empties, configuration registers take their defaults; the node
// store is not cleared and holds nothing meaningful until written.
module triangle_mesh_warp_lookup import tmwl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // node_index[12:0] node_u[32:13] node_v[52:33]
                                     // pixel_x[64:53] pixel_y[76:65], zero fill
  input  logic [0:0]  s_axis_tuser,  // req_type[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // mapped_x[15:0] mapped_y[31:16]
  output logic [0:0]  m_axis_tuser,  // out_of_mesh[0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  localparam int NSTG = 10;
  localparam logic signed [WGT_W-1:0] W_ONE = WGT_W'(1) << GRID_FRAC;
  localparam logic [1:0] NODE_0 = 2'd0;
  localparam logic [1:0] NODE_1 = 2'd1;
  localparam logic [1:0] NODE_2 = 2'd2;
  localparam logic [1:0] NODE_3 = 2'd3;

  // ---------------- configuration ----------------
  logic [23:0]        inv_step_x_q, inv_step_y_q;
  logic [7:0]         last_column_q;
  logic [13:0]        texture_size_q;
  logic [11:0]        tex_offset_x_q, tex_offset_y_q;
  logic signed [12:0] origin_x_q, origin_y_q;

  assign cfg_ready_o = 1'b1;

  // Take register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_step_x_q   <= 24'd1048576;
      inv_step_y_q   <= 24'd1048576;
      last_column_q  <= 8'd80;
      texture_size_q <= 14'd1024;
      tex_offset_x_q <= '0;
      tex_offset_y_q <= '0;
      origin_x_q     <= '0;
      origin_y_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_INV_STEP_X:   inv_step_x_q   <= cfg_data_i;
        REG_INV_STEP_Y:   inv_step_y_q   <= cfg_data_i;
        REG_LAST_COLUMN:  last_column_q  <= cfg_data_i[7:0];
        REG_TEXTURE_SIZE: texture_size_q <= cfg_data_i[13:0];
        REG_TEX_OFFSET_X: tex_offset_x_q <= cfg_data_i[11:0];
        REG_TEX_OFFSET_Y: tex_offset_y_q <= cfg_data_i[11:0];
        REG_ORIGIN_X:     origin_x_q     <= signed'(cfg_data_i[12:0]);
        REG_ORIGIN_Y:     origin_y_q     <= signed'(cfg_data_i[12:0]);
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic [NSTG:1]   vld_q;
  logic [NSTG+1:1] adv;
  logic            s4_map;

  always_comb begin
    adv[NSTG+1] = m_axis_tready;
    for (int k = NSTG; k >= 1; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  // Advance valid bits; write transactions leave after the store stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[1]) vld_q[1] <= s_axis_tvalid;
      for (int k = 2; k <= NSTG; k++) begin
        if (adv[k]) vld_q[k] <= (k == 5) ? (vld_q[4] && s4_map) : vld_q[k-1];
      end
    end
  end

  assign s_axis_tready = adv[1];

  // ---------------- stage 1: input register ----------------
  logic         s1_map_q;
  logic [12:0]  s1_idx_q;
  node_t        s1_node_q;
  logic [11:0]  s1_px_q, s1_py_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s1_map_q    <= s_axis_tuser[0];
      s1_idx_q    <= s_axis_tdata[12:0];
      s1_node_q.u <= signed'(s_axis_tdata[32:13]);
      s1_node_q.v <= signed'(s_axis_tdata[52:33]);
      s1_px_q     <= s_axis_tdata[64:53];
      s1_py_q     <= s_axis_tdata[76:65];
    end
  end

  // ---------------- stage 2: grid products ----------------
  logic        s2_map_q;
  logic [12:0] s2_idx_q;
  node_t       s2_node_q;
  logic [35:0] s2_yq_q, s2_xq_q;
  logic [35:0] s2_yq_d, s2_xq_d;

  assign s2_yq_d = s1_py_q * inv_step_y_q;
  assign s2_xq_d = s1_px_q * inv_step_x_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s2_map_q  <= s1_map_q;
      s2_idx_q  <= s1_idx_q;
      s2_node_q <= s1_node_q;
      s2_yq_q   <= s2_yq_d;
      s2_xq_q   <= s2_xq_d;
    end
  end

  // ---------------- stage 3: row, column and fractions ----------------
  logic        s3_map_q;
  logic [12:0] s3_idx_q;
  node_t       s3_node_q;
  logic [11:0] s3_j_q;
  logic [12:0] s3_i_q;
  logic [24:0] s3_dx_q, s3_dy_q, s3_half_q;
  logic [24:0] s3_half_d;
  logic [37:0] s3_xq_d;

  // The column shift grows from zero to half a column pitch down an even row and falls back down an odd row
  assign s3_half_d = s2_yq_q[24] ? (25'd16777216 - {1'b0, s2_yq_q[23:0]})
                                 : {1'b0, s2_yq_q[23:0]};
  assign s3_xq_d   = {1'b0, s2_xq_q, 1'b0} + {13'd0, s3_half_d};

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      s3_map_q  <= s2_map_q;
      s3_idx_q  <= s2_idx_q;
      s3_node_q <= s2_node_q;
      s3_j_q    <= s2_yq_q[35:24];
      s3_i_q    <= s3_xq_d[37:25];
      s3_dx_q   <= s3_xq_d[24:0];
      s3_dy_q   <= {s2_yq_q[23:0], 1'b0};
      s3_half_q <= s3_half_d;
    end
  end

  // ---------------- stage 4: node address base ----------------
  logic        s4_map_q, s4_odd_q;
  logic [12:0] s4_idx_q;
  node_t       s4_node_q;
  logic [12:0] s4_i_q;
  logic [24:0] s4_dx_q, s4_dy_q, s4_half_q;
  logic [21:0] s4_base_q;
  logic [8:0]  cols;

  assign cols = {1'b0, last_column_q} + 9'd1;

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      s4_map_q  <= s3_map_q;
      s4_odd_q  <= s3_j_q[0];
      s4_idx_q  <= s3_idx_q;
      s4_node_q <= s3_node_q;
      s4_i_q    <= s3_i_q;
      s4_dx_q   <= s3_dx_q;
      s4_dy_q   <= s3_dy_q;
      s4_half_q <= s3_half_q;
      s4_base_q <= 22'(s3_j_q) * 22'(cols) + 22'(s3_i_q);
    end
  end

  // ---------------- stage 4 logic: triangle choice, store access ----------------
  logic                             s4_oom, s4_first, s4_widen;
  logic signed [WGT_W-1:0]          dx_s, dy_s, half_s, dxw, s4_wb, s4_wc;
  logic [1:0]                       s4_sel_a, s4_sel_b, s4_sel_c;
  logic [NUM_READS-1:0][ADDR_W-1:0] raddr;
  mem_wr_t                          mem_wr;
  node_t [NUM_READS-1:0]            rnode;

  assign s4_map = (s4_map_q == REQ_MAP);
  assign s4_oom = ({4'd0, s4_i_q} >= {9'd0, last_column_q}) ||
                  (23'(s4_base_q) + 23'(cols) + 23'd1 >= 23'(MESH_DEPTH));

  assign dx_s   = signed'(WGT_W'(s4_dx_q));
  assign dy_s   = signed'(WGT_W'(s4_dy_q));
  assign half_s = signed'(WGT_W'(s4_half_q));

  // Pick the triangle and widen the half triangles at the edge columns
  always_comb begin
    if (s4_odd_q) begin
      s4_first = ({1'b0, s4_dx_q} + {1'b0, s4_dy_q}) <= 26'd33554432;
      s4_widen = s4_first ? (s4_i_q == 13'd0)
                          : ({4'd0, s4_i_q} == ({9'd0, last_column_q} - 17'd1));
    end else begin
      s4_first = s4_dx_q >= s4_dy_q;
      s4_widen = s4_first ? ({4'd0, s4_i_q} == ({9'd0, last_column_q} - 17'd1))
                          : (s4_i_q == 13'd0);
    end
    dxw = s4_widen ? ((dx_s - half_s) <<< 1) : dx_s;
    case ({s4_odd_q, s4_first})
      2'b11: begin
        s4_sel_a = NODE_0; s4_sel_b = NODE_1; s4_sel_c = NODE_2;
        s4_wb = dxw; s4_wc = dy_s;
      end
      2'b10: begin
        s4_sel_a = NODE_3; s4_sel_b = NODE_1; s4_sel_c = NODE_2;
        s4_wb = W_ONE - dy_s; s4_wc = W_ONE - dxw;
      end
      2'b01: begin
        s4_sel_a = NODE_1; s4_sel_b = NODE_0; s4_sel_c = NODE_3;
        s4_wb = W_ONE - dxw; s4_wc = dy_s;
      end
      default: begin
        s4_sel_a = NODE_2; s4_sel_b = NODE_0; s4_sel_c = NODE_3;
        s4_wb = W_ONE - dy_s; s4_wc = dxw;
      end
    endcase
  end

  assign raddr[0] = s4_base_q[ADDR_W-1:0];
  assign raddr[1] = raddr[0] + ADDR_W'(1);
  assign raddr[2] = raddr[0] + ADDR_W'(cols);
  assign raddr[3] = raddr[2] + ADDR_W'(1);

  // Write a node when its transaction leaves the store stage
  assign mem_wr.we    = vld_q[4] && adv[5] && (s4_map_q == REQ_WRITE) &&
                        ({4'd0, s4_idx_q} < 17'(MESH_DEPTH));
  assign mem_wr.waddr = s4_idx_q[ADDR_W-1:0];
  assign mem_wr.wdata = s4_node_q;

  tmwl_mesh_mem u_mesh_mem (
    .clk_i   (clk_i),
    .wr_i    (mem_wr),
    .re_i    (adv[5]),
    .raddr_i (raddr),
    .rdata_o (rnode)
  );

  // ---------------- stage 5: node read ----------------
  logic                    s5_oom_q;
  logic [1:0]              s5_sel_a_q, s5_sel_b_q, s5_sel_c_q;
  logic signed [WGT_W-1:0] s5_wb_q, s5_wc_q;

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      s5_oom_q   <= s4_oom;
      s5_sel_a_q <= s4_sel_a;
      s5_sel_b_q <= s4_sel_b;
      s5_sel_c_q <= s4_sel_c;
      s5_wb_q    <= s4_wb;
      s5_wc_q    <= s4_wc;
    end
  end

  // ---------------- stage 6: node differences ----------------
  node_t                    na, nb, nc;
  logic                     s6_oom_q;
  logic signed [COORD_W-1:0] s6_au_q, s6_av_q;
  logic signed [DIFF_W-1:0] s6_dbu_q, s6_dcu_q, s6_dbv_q, s6_dcv_q;
  logic signed [WGT_W-1:0]  s6_wb_q, s6_wc_q;

  assign na = rnode[s5_sel_a_q];
  assign nb = rnode[s5_sel_b_q];
  assign nc = rnode[s5_sel_c_q];

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      s6_oom_q <= s5_oom_q;
      s6_au_q  <= na.u;
      s6_av_q  <= na.v;
      s6_dbu_q <= DIFF_W'(nb.u) - DIFF_W'(na.u);
      s6_dcu_q <= DIFF_W'(nc.u) - DIFF_W'(na.u);
      s6_dbv_q <= DIFF_W'(nb.v) - DIFF_W'(na.v);
      s6_dcv_q <= DIFF_W'(nc.v) - DIFF_W'(na.v);
      s6_wb_q  <= s5_wb_q;
      s6_wc_q  <= s5_wc_q;
    end
  end

  // ---------------- stage 7: weight products ----------------
  logic                      s7_oom_q;
  logic signed [COORD_W-1:0] s7_au_q, s7_av_q;
  logic signed [PROD_W-1:0]  s7_pbu_q, s7_pcu_q, s7_pbv_q, s7_pcv_q;

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      s7_oom_q <= s6_oom_q;
      s7_au_q  <= s6_au_q;
      s7_av_q  <= s6_av_q;
      s7_pbu_q <= s6_wb_q * s6_dbu_q;
      s7_pcu_q <= s6_wc_q * s6_dcu_q;
      s7_pbv_q <= s6_wb_q * s6_dbv_q;
      s7_pcv_q <= s6_wc_q * s6_dcv_q;
    end
  end

  // ---------------- stage 8: blend sums ----------------
  logic                    s8_oom_q;
  logic signed [ACC_W-1:0] s8_accu_q, s8_accv_q;
  logic signed [ACC_W-1:0] au_w, av_w;

  assign au_w = ACC_W'(s7_au_q) <<< GRID_FRAC;
  assign av_w = ACC_W'(s7_av_q) <<< GRID_FRAC;

  always_ff @(posedge clk_i) begin
    if (adv[8]) begin
      s8_oom_q  <= s7_oom_q;
      s8_accu_q <= au_w + ACC_W'(s7_pbu_q) + ACC_W'(s7_pcu_q);
      s8_accv_q <= av_w + ACC_W'(s7_pbv_q) + ACC_W'(s7_pcv_q);
    end
  end

  // ---------------- stage 9: texture scaling, split products ----------------
  localparam int LO_W = GRID_FRAC;
  localparam int HI_W = ACC_W - GRID_FRAC;
  logic                        s9_oom_q;
  logic [LO_W+13:0]            s9_lou_q, s9_lov_q;
  logic signed [HI_W+14:0]     s9_hiu_q, s9_hiv_q;
  logic signed [14:0]          ts_s;

  assign ts_s = signed'({1'b0, texture_size_q});

  always_ff @(posedge clk_i) begin
    if (adv[9]) begin
      s9_oom_q <= s8_oom_q;
      s9_lou_q <= s8_accu_q[LO_W-1:0] * texture_size_q;
      s9_lov_q <= s8_accv_q[LO_W-1:0] * texture_size_q;
      s9_hiu_q <= signed'(s8_accu_q[ACC_W-1:LO_W]) * ts_s;
      s9_hiv_q <= signed'(s8_accv_q[ACC_W-1:LO_W]) * ts_s;
    end
  end

  // ---------------- stage 10: round, offset, saturate ----------------
  logic signed [65:0] vu, vv;
  logic signed [24:0] ru, rv;
  logic signed [25:0] tu, tv;
  logic signed [15:0] mx_d, my_d;
  logic signed [15:0] mx_q, my_q;
  logic               oom_q;

  // Round once: floor of scaled value plus one half
  assign vu = (66'(s9_hiu_q) <<< LO_W) + signed'(66'(s9_lou_q)) +
              signed'(66'(1) << (RND_SHIFT - 1));
  assign vv = (66'(s9_hiv_q) <<< LO_W) + signed'(66'(s9_lov_q)) +
              signed'(66'(1) << (RND_SHIFT - 1));
  assign ru = 25'(vu >>> RND_SHIFT);
  assign rv = 25'(vv >>> RND_SHIFT);
  assign tu = 26'(ru) - signed'(26'(tex_offset_x_q)) + 26'(origin_x_q);
  assign tv = 26'(rv) - signed'(26'(tex_offset_y_q)) + 26'(origin_y_q);

  always_comb begin
    if (tu > 26'sd32767)       mx_d = 16'sh7FFF;
    else if (tu < -26'sd32768) mx_d = -16'sh8000;
    else                       mx_d = 16'(tu);
    if (tv > 26'sd32767)       my_d = 16'sh7FFF;
    else if (tv < -26'sd32768) my_d = -16'sh8000;
    else                       my_d = 16'(tv);
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk_i) begin
    if (adv[10]) begin
      oom_q <= s9_oom_q;
      mx_q  <= s9_oom_q ? '0 : mx_d;
      my_q  <= s9_oom_q ? '0 : my_d;
    end
  end

  assign m_axis_tvalid = vld_q[NSTG];
  assign m_axis_tdata  = {my_q, mx_q};
  assign m_axis_tuser  = oom_q;

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the triangle mesh warp lookup.

// One expected result transaction
typedef struct {
  logic signed [15:0] mx;
  logic signed [15:0] my;
  logic               oom;
} warp_result_t;

// Expected-result store and mesh predictor for the warp lookup
class warp_scoreboard;
  localparam longint GRID_ONE = 64'sd1 << tmwl_pkg::GRID_FRAC;

  logic signed [19:0] mesh_u [tmwl_pkg::MESH_DEPTH];
  logic signed [19:0] mesh_v [tmwl_pkg::MESH_DEPTH];
  bit                 written[tmwl_pkg::MESH_DEPTH];
  longint inv_x, inv_y, last_col, tex_size, off_x, off_y, org_x, org_y;
  warp_result_t pending_q[$];
  int errors;

  function new();
    inv_x = 1048576; inv_y = 1048576; last_col = 80; tex_size = 1024;
    off_x = 0; off_y = 0; org_x = 0; org_y = 0;
    errors = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [23:0] d);
    case (idx)
      tmwl_pkg::REG_INV_STEP_X:   inv_x    = longint'(d);
      tmwl_pkg::REG_INV_STEP_Y:   inv_y    = longint'(d);
      tmwl_pkg::REG_LAST_COLUMN:  last_col = longint'(d[7:0]);
      tmwl_pkg::REG_TEXTURE_SIZE: tex_size = longint'(d[13:0]);
      tmwl_pkg::REG_TEX_OFFSET_X: off_x    = longint'(d[11:0]);
      tmwl_pkg::REG_TEX_OFFSET_Y: off_y    = longint'(d[11:0]);
      tmwl_pkg::REG_ORIGIN_X:     org_x    = longint'($signed(d[12:0]));
      tmwl_pkg::REG_ORIGIN_Y:     org_y    = longint'($signed(d[12:0]));
      default: ;
    endcase
  endfunction

  // Scale, round half up, move into the viewport and saturate
  function logic signed [15:0] to_viewport(longint acc, longint off, longint org);
    longint v;
    v = acc * tex_size + (64'sd1 <<< (tmwl_pkg::RND_SHIFT - 1));
    v = (v >>> tmwl_pkg::RND_SHIFT) - off + org;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Locate the cell and triangle and blend; safe is 0 when an unwritten node is read
  function void lookup(logic [11:0] px, logic [11:0] py,
                       output warp_result_t r, output bit safe);
    longint yq, j, fy, dy, half, xq, i, dx, cols, base;
    longint n0, n1, n2, n3, na, nb, nc, wb, wc, au, av;
    yq = longint'(py) * inv_y;
    j = yq >>> 24;
    fy = yq & 64'hFFFFFF;
    dy = fy * 2;
    half = j[0] ? (GRID_ONE / 2 - fy) : fy;
    xq = longint'(px) * inv_x * 2 + half;
    i = xq >>> tmwl_pkg::GRID_FRAC;
    dx = xq & (GRID_ONE - 1);
    cols = last_col + 1;
    base = j * cols + i;
    r.mx = '0; r.my = '0; r.oom = 1'b1; safe = 1'b1;
    if (i >= last_col || base + cols + 1 >= tmwl_pkg::MESH_DEPTH) return;
    n0 = base; n1 = base + 1; n2 = base + cols; n3 = n2 + 1;
    if (j[0]) begin
      if (dx + dy <= GRID_ONE) begin
        // Widen the half triangle at the left edge
        if (i == 0) dx = 2 * (dx - half);
        na = n0; nb = n1; nc = n2; wb = dx; wc = dy;
      end else begin
        if (i == last_col - 1) dx = 2 * (dx - half);
        na = n3; nb = n1; nc = n2; wb = GRID_ONE - dy; wc = GRID_ONE - dx;
      end
    end else begin
      if (dx >= dy) begin
        if (i == last_col - 1) dx = 2 * (dx - half);
        na = n1; nb = n0; nc = n3; wb = GRID_ONE - dx; wc = dy;
      end else begin
        if (i == 0) dx = 2 * (dx - half);
        na = n2; nb = n0; nc = n3; wb = GRID_ONE - dy; wc = dx;
      end
    end
    safe = written[na] && written[nb] && written[nc];
    au = longint'(mesh_u[na]) * GRID_ONE
       + wb * (longint'(mesh_u[nb]) - longint'(mesh_u[na]))
       + wc * (longint'(mesh_u[nc]) - longint'(mesh_u[na]));
    av = longint'(mesh_v[na]) * GRID_ONE
       + wb * (longint'(mesh_v[nb]) - longint'(mesh_v[na]))
       + wc * (longint'(mesh_v[nc]) - longint'(mesh_v[na]));
    r.mx = to_viewport(au, off_x, org_x);
    r.my = to_viewport(av, off_y, org_y);
    r.oom = 1'b0;
  endfunction

  // Note an accepted input transaction
  function void note_input(logic req, logic [79:0] d);
    warp_result_t r;
    bit safe;
    if (req == tmwl_pkg::REQ_WRITE) begin
      if (d[12:0] < tmwl_pkg::MESH_DEPTH) begin
        mesh_u[d[12:0]] = d[32:13];
        mesh_v[d[12:0]] = d[52:33];
        written[d[12:0]] = 1'b1;
      end
    end else begin
      lookup(d[64:53], d[76:65], r, safe);
      pending_q.push_back(r);
    end
  endfunction

  // Compare an accepted result with the oldest expectation
  function void check(logic [31:0] d, logic oom);
    warp_result_t r;
    if (pending_q.size() == 0) begin
      $error("unexpected result transaction: mapped_x %0d", $signed(d[15:0]));
      errors++;
      return;
    end
    r = pending_q.pop_front();
    if (d[15:0] !== r.mx) begin
      $error("mapped_x: expected %0d, actual %0d", r.mx, $signed(d[15:0]));
      errors++;
    end
    if (d[31:16] !== r.my) begin
      $error("mapped_y: expected %0d, actual %0d", r.my, $signed(d[31:16]));
      errors++;
    end
    if (oom !== r.oom) begin
      $error("out_of_mesh: expected %0b, actual %0b", r.oom, oom);
      errors++;
    end
  endfunction
endclass

module testbench import tmwl_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 20;
  localparam int FILL_NODES = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;

  warp_scoreboard sb = new();
  int idle_cycles = 0;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;

  triangle_mesh_warp_lookup dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Track accepted transactions on every channel
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tuser[0], s_axis_tdata);
    if (m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata, m_axis_tuser[0]);
    if (cfg_valid_i && cfg_ready_o) sb.set_reg(cfg_index_i, cfg_data_i);
  end

  // Drop the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: random stall before each result, with burst stretches
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  task automatic send_item(logic req, logic [79:0] d);
    int gap;
    if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = req;
    s_axis_tdata = d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_write(logic [12:0] idx, logic [19:0] u, logic [19:0] v);
    send_item(REQ_WRITE, {27'b0, v, u, idx});
  endtask

  // Send a map transaction only when it reads no unwritten node
  task automatic send_map(logic [11:0] px, logic [11:0] py);
    warp_result_t r;
    bit safe;
    sb.lookup(px, py, r, safe);
    if (safe) send_item(REQ_MAP, {3'b0, py, px, 40'b0, 13'b0});
  endtask

  task automatic random_map();
    warp_result_t r;
    bit safe;
    logic [11:0] px, py;
    int lim;
    for (int t = 0; t < 100; t++) begin
      if ($urandom_range(0, 3) == 0) begin
        px = 12'($urandom); py = 12'($urandom);
      end else begin
        lim = $urandom_range(3, 255);
        px = 12'($urandom_range(0, lim)); py = 12'($urandom_range(0, lim));
      end
      sb.lookup(px, py, r, safe);
      if (safe) begin
        send_item(REQ_MAP, {3'b0, py, px, 40'b0, 13'b0});
        return;
      end
    end
    send_write(13'($urandom_range(0, 1023)), 20'($urandom), 20'($urandom));
  endtask

  task automatic random_traffic(int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) < 3) begin
        if ($urandom_range(0, 9) < 7) begin
          send_write(13'($urandom_range(0, 1023)), 20'($urandom), 20'($urandom));
        end else begin
          send_write(13'($urandom), 20'($urandom), 20'($urandom));
        end
      end else begin
        random_map();
      end
    end
  endtask

  task automatic cfg_write(logic [2:0] idx, int d);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = d[23:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Hold input until the block drains, then reprogram every register
  task automatic apply_settings(int ix, int iy, int lc, int ts, int ox, int oy,
                                int gx, int gy);
    s_axis_tvalid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
    cfg_write(REG_INV_STEP_X, ix);
    cfg_write(REG_INV_STEP_Y, iy);
    cfg_write(REG_LAST_COLUMN, lc);
    cfg_write(REG_TEXTURE_SIZE, ts);
    cfg_write(REG_TEX_OFFSET_X, ox);
    cfg_write(REG_TEX_OFFSET_Y, oy);
    cfg_write(REG_ORIGIN_X, gx);
    cfg_write(REG_ORIGIN_Y, gy);
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Fill the low part of the mesh so maps land on written nodes
    for (int n = 0; n < FILL_NODES; n++) send_write(13'(n), 20'($urandom), 20'($urandom));

    // Directed: coordinate extremes, corner pixels, top store entry
    send_write(13'd8191, 20'h7FFFF, 20'h80000);
    send_write(13'd0, 20'h80000, 20'h7FFFF);
    send_write(13'd1, 20'h7FFFF, 20'h7FFFF);
    send_write(13'd81, 20'h80000, 20'h80000);
    send_map(12'd0, 12'd0);
    send_map(12'd4095, 12'd4095);
    send_map(12'd0, 12'd4095);
    send_map(12'd4095, 12'd0);
    send_map(12'd15, 12'd1);
    send_map(12'd1, 12'd15);
    send_map(12'd8, 12'd20);
    send_map(12'd1270, 12'd3);
    send_map(12'd1279, 12'd24);
    send_map(12'd3, 12'd30);
    random_traffic(ITEMS_PER_PHASE);

    // Largest reciprocals, narrowest mesh, smallest texture, lowest origin
    apply_settings(24'hFFFFFF, 24'hFFFFFF, 2, 1, 0, 0, -4096, -4096);
    send_map(12'd0, 12'd0);
    random_traffic(ITEMS_PER_PHASE);

    // Zero reciprocals, widest mesh, texture size 8192, largest offsets
    apply_settings(0, 0, 255, 8192, 4095, 4095, 4095, 4095);
    send_map(12'd4095, 12'd4095);
    random_traffic(ITEMS_PER_PHASE);

    // Random settings
    repeat (2) begin
      apply_settings($urandom_range(1 << 19, 1 << 23), $urandom_range(1 << 19, 1 << 23),
                     $urandom_range(2, 255), $urandom_range(1, 8192),
                     $urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096);
      random_traffic(ITEMS_PER_PHASE);
    end

    // Drain and settle
    s_axis_tvalid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// File: triangle_mesh_warp_lookup.f
rtl/core/tmwl_pkg.sv
rtl/core/tmwl_mesh_mem.sv
rtl/core/triangle_mesh_warp_lookup.sv
bench/testbench.sv
